FILE: rtl/core/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared widths, controller states and control/status bundles for the
// lap interval statistics block.
// ----------------------------------------------------------------------------
package lis_pkg;

	localparam int LANE_W  = 6;
	localparam int STAMP_W = 48;
	localparam int COUNT_W = 32;
	localparam int MEAN_W  = 64;
	localparam int FRAC_W  = 16;

	localparam int DIV_STEPS = MEAN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [STAMP_W-1:0] NO_BEST   = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EVAL  = 6'b000010,
		ST_DIFF  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_APPLY = 6'b010000,
		ST_FIN   = 6'b100000
	} lis_state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic div_start;
		logic apply;
		logic publish;
	} lis_cmd_t;

	typedef struct packed {
		logic record;
		logic div_done;
	} lis_sts_t;

endpackage

FILE: rtl/core/lis_div.sv
// ----------------------------------------------------------------------------
// lis_div
// Restoring divider, one quotient bit per cycle: 64-bit dividend over a
// nonzero 32-bit divisor, quotient truncated.
// ----------------------------------------------------------------------------
module lis_div
	import lis_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MEAN_W-1:0]  dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [MEAN_W-1:0]  quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MEAN_W-1:0]    work_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   divisor_q;

	logic [COUNT_W:0] trial;
	logic [COUNT_W:0] trial_sub;
	logic             fits;

	assign trial     = {rem_q, work_q[MEAN_W-1]};
	assign trial_sub = trial - {1'b0, divisor_q};
	assign fits      = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[MEAN_W-2:0], fits};
			rem_q  <= fits ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

FILE: rtl/core/lis_ctrl.sv
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer for one passing event: evaluate, mean update through the
// divider when a lap is recorded, then hand the word to the output register.
// ----------------------------------------------------------------------------
module lis_ctrl
	import lis_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  lis_sts_t sts,
	output lis_cmd_t cmd
);

	lis_state_t state_q;
	lis_state_t state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = sts.record ? ST_DIFF : ST_FIN;
			end
			ST_DIFF: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.publish = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/lis_dp.sv
// ----------------------------------------------------------------------------
// lis_dp
// Lap datapath: lane filter, stored stamp, lap count, best lap, running
// mean with its serial divider, and the output word register.
// ----------------------------------------------------------------------------
module lis_dp
	import lis_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LANE_W-1:0]  cfg_wdata,
	input  logic [LANE_W-1:0]  lane,
	input  logic [STAMP_W-1:0] timestamp_us,
	input  lis_cmd_t           cmd,
	output lis_sts_t           sts,
	output logic               updated,
	output logic               new_best,
	output logic [STAMP_W-1:0] lap_time_us,
	output logic [COUNT_W-1:0] laps_done,
	output logic [MEAN_W-1:0]  mean_lap,
	output logic [STAMP_W-1:0] best_lap_us
);

	logic [LANE_W-1:0]  lane_id_q;
	logic [LANE_W-1:0]  lane_q;
	logic [STAMP_W-1:0] stamp_q;

	logic [STAMP_W-1:0] prev_q;
	logic               have_prev_q;
	logic [STAMP_W-1:0] last_lap_q;
	logic [COUNT_W-1:0] total_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [STAMP_W-1:0] best_q;
	logic               upd_q;
	logic               nbest_q;
	logic               neg_q;

	logic [STAMP_W-1:0] out_lap_q;
	logic [COUNT_W-1:0] out_total_q;
	logic [MEAN_W-1:0]  out_mean_q;
	logic [STAMP_W-1:0] out_best_q;
	logic               out_upd_q;
	logic               out_nbest_q;

	logic               match;
	logic               record;
	logic [STAMP_W-1:0] lap;
	logic               beats;
	logic [MEAN_W-1:0]  target;
	logic [MEAN_W:0]    up_diff;
	logic [MEAN_W-1:0]  down_diff;
	logic [MEAN_W-1:0]  magnitude;
	logic               div_done;
	logic [MEAN_W-1:0]  quotient;

	assign match  = (lane_q == lane_id_q);
	assign record = match && have_prev_q && (stamp_q > prev_q);
	assign lap    = stamp_q - prev_q;
	assign beats  = (total_q == '0) || (lap < best_q);

	// Form |target - mean| with the sign taken from the borrow.
	assign target    = {last_lap_q, {FRAC_W{1'b0}}};
	assign up_diff   = {1'b0, target} - {1'b0, mean_q};
	assign down_diff = mean_q - target;
	assign magnitude = up_diff[MEAN_W] ? down_diff : up_diff[MEAN_W-1:0];

	assign sts.record   = record;
	assign sts.div_done = div_done;

	lis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (magnitude),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_id_q   <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			last_lap_q  <= '0;
			total_q     <= '0;
			mean_q      <= '0;
			best_q      <= NO_BEST;
		end else begin
			if (cfg_we) begin
				lane_id_q <= cfg_wdata;
			end
			if (cmd.eval && match) begin
				prev_q      <= stamp_q;
				have_prev_q <= 1'b1;
			end
			if (cmd.eval && record) begin
				last_lap_q <= lap;
				if (total_q != COUNT_MAX) begin
					total_q <= total_q + 1'b1;
				end
				if (beats) begin
					best_q <= lap;
				end
			end
			if (cmd.apply) begin
				mean_q <= neg_q ? mean_q - quotient : mean_q + quotient;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lane_q  <= lane;
			stamp_q <= timestamp_us;
		end
		if (cmd.eval) begin
			upd_q   <= record;
			nbest_q <= record && beats;
		end
		if (cmd.div_start) begin
			neg_q <= up_diff[MEAN_W];
		end
		if (cmd.publish) begin
			out_upd_q   <= upd_q;
			out_nbest_q <= nbest_q;
			out_lap_q   <= last_lap_q;
			out_total_q <= total_q;
			out_mean_q  <= mean_q;
			out_best_q  <= best_q;
		end
	end

	assign updated     = out_upd_q;
	assign new_best    = out_nbest_q;
	assign lap_time_us = out_lap_q;
	assign laps_done   = out_total_q;
	assign mean_lap    = out_mean_q;
	assign best_lap_us = out_best_q;

endmodule

FILE: rtl/core/lap_interval_statistics.sv
// ----------------------------------------------------------------------------
// lap_interval_statistics
// Lap time, lap count, best lap and running mean for the configured lane.
// ----------------------------------------------------------------------------
// Sequence: a recorded lap passes through evaluate, divider start, the bit-serial
//   mean divider, mean update and publish; otherwise evaluate, then publish.
// Flow: one word at a time; the next input is taken once the result has
//   moved to the output register.
// Reset: arst_n clears lane_id, count, mean and stored stamp, sets best lap
//   to all ones; no output word is pending after reset.
module lap_interval_statistics
	import lis_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LANE_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LANE_W-1:0]  lane,
	input  logic [STAMP_W-1:0] timestamp_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               updated,
	output logic               new_best,
	output logic [STAMP_W-1:0] lap_time_us,
	output logic [COUNT_W-1:0] laps_done,
	output logic [MEAN_W-1:0]  mean_lap,
	output logic [STAMP_W-1:0] best_lap_us
);

	lis_cmd_t cmd;
	lis_sts_t sts;

	lis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lis_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.lane         (lane),
		.timestamp_us (timestamp_us),
		.cmd          (cmd),
		.sts          (sts),
		.updated      (updated),
		.new_best     (new_best),
		.lap_time_us  (lap_time_us),
		.laps_done    (laps_done),
		.mean_lap     (mean_lap),
		.best_lap_us  (best_lap_us)
	);

endmodule

FILE: rtl/core/lis_checker.sv
// ----------------------------------------------------------------------------
// lis_checker
// Port-level checks on the lap statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module lis_checker
	import lis_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               updated,
	input logic               new_best,
	input logic [STAMP_W-1:0] lap_time_us,
	input logic [COUNT_W-1:0] laps_done,
	input logic [MEAN_W-1:0]  mean_lap,
	input logic [STAMP_W-1:0] best_lap_us
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_lap) && $stable(laps_done))
		else $error("output word changed while stalled");

	a_best_needs_lap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_best |-> updated)
		else $error("new best flagged without a recorded lap");

	// one passing event in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an event is in flight");

	a_best_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_best |-> best_lap_us == lap_time_us)
		else $error("new best differs from lap time");

	a_best_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && updated && !new_best |-> best_lap_us <= lap_time_us)
		else $error("recorded lap below best without new best flag");

endmodule

bind lap_interval_statistics lis_checker u_lis_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.updated     (updated),
	.new_best    (new_best),
	.lap_time_us (lap_time_us),
	.laps_done   (laps_done),
	.mean_lap    (mean_lap),
	.best_lap_us (best_lap_us)
);
